// ===== rtl/lcbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared types, brand codes and constants for the card brand checker.
// ----------------------------------------------------------------------------
package lcbc_pkg;

  localparam int unsigned NumWidth   = 63;
  localparam int unsigned NumDigits  = 19;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned DigitWidth = 4;

  // Card lengths and leading digits used for classification
  localparam logic [CountWidth-1:0] LenVisaShort  = 5'd13;
  localparam logic [CountWidth-1:0] LenAmex       = 5'd15;
  localparam logic [CountWidth-1:0] LenLong       = 5'd16;
  localparam logic [DigitWidth-1:0] LeadVisa      = 4'd4;
  localparam logic [DigitWidth-1:0] LeadAmexHi    = 4'd3;
  localparam logic [DigitWidth-1:0] LeadAmexLoA   = 4'd4;
  localparam logic [DigitWidth-1:0] LeadAmexLoB   = 4'd7;
  localparam logic [DigitWidth-1:0] LeadMcHi      = 4'd5;
  localparam logic [DigitWidth-1:0] LeadMcLoMin   = 4'd1;
  localparam logic [DigitWidth-1:0] LeadMcLoMax   = 4'd5;

  typedef enum logic [1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_AMEX       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_VISA       = 2'd3
  } brand_t;

  // One in-flight item of the digit pipeline
  typedef struct packed {
    logic                  valid;
    logic [NumWidth-1:0]   rest;
    logic [DigitWidth-1:0] sum;      // Luhn sum mod 10
    logic [CountWidth-1:0] count;    // 0 until the first nonzero digit
    logic [DigitWidth-1:0] lead_hi;
    logic [DigitWidth-1:0] lead_lo;
  } stage_t;

  typedef struct packed {
    logic                  valid;
    brand_t                brand;
    logic                  checksum_ok;
    logic [CountWidth-1:0] digit_count;
  } result_t;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

// ===== rtl/lcbc_card_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_card_if
// Valid/ready channel carrying one binary card number.
// ----------------------------------------------------------------------------
interface lcbc_card_if;
  logic                         valid;
  logic                         ready;
  logic [lcbc_pkg::NumWidth-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

// ===== rtl/lcbc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_result_if
// Valid/ready channel carrying one brand check result.
// ----------------------------------------------------------------------------
interface lcbc_result_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     brand;
  logic                           checksum_ok;
  logic [lcbc_pkg::CountWidth-1:0] digit_count;

  modport source (output valid, output brand, output checksum_ok, output digit_count,
                  input ready);
  modport sink (input valid, input brand, input checksum_ok, input digit_count,
                output ready);
endinterface

// ===== rtl/lcbc_digit_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_digit_stage
// Extracts the decimal digit at one fixed position and folds it into the
// Luhn sum, digit count and leading-digit capture.
// ----------------------------------------------------------------------------
module lcbc_digit_stage #(
  parameter int unsigned POS = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lcbc_pkg::stage_t  d,
  output lcbc_pkg::stage_t  q
);

  localparam logic [63:0] Weight = lcbc_pkg::pow10(POS);

  logic [lcbc_pkg::DigitWidth-1:0] digit;
  logic [63:0]                     sub;
  logic [lcbc_pkg::DigitWidth-1:0] luhn_digit;
  logic [lcbc_pkg::DigitWidth:0]   sum_raw;
  lcbc_pkg::stage_t                nxt;

  // Largest multiple of the position weight that still fits in the rest
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int unsigned k = 1; k < 10; k++) begin
      if ({1'b0, d.rest} >= 64'(k) * Weight) begin
        digit = lcbc_pkg::DigitWidth'(k);
        sub   = 64'(k) * Weight;
      end
    end
  end

  always_comb begin
    luhn_digit = digit;
    if (POS % 2 == 1) begin
      if (digit >= 4'd5) begin
        luhn_digit = lcbc_pkg::DigitWidth'({digit, 1'b0} - 5'd9);
      end else begin
        luhn_digit = lcbc_pkg::DigitWidth'({digit, 1'b0});
      end
    end
    sum_raw = {1'b0, d.sum} + {1'b0, luhn_digit};

    nxt       = d;
    nxt.rest  = d.rest - sub[lcbc_pkg::NumWidth-1:0];
    nxt.sum   = (sum_raw >= 5'd10) ? lcbc_pkg::DigitWidth'(sum_raw - 5'd10)
                                   : sum_raw[lcbc_pkg::DigitWidth-1:0];
    if (d.count == '0 && digit != '0) begin
      nxt.count   = lcbc_pkg::CountWidth'(POS + 1);
      nxt.lead_hi = digit;
    end
    if (d.count == lcbc_pkg::CountWidth'(POS + 2)) begin
      nxt.lead_lo = digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.rest    <= nxt.rest;
      q.sum     <= nxt.sum;
      q.count   <= nxt.count;
      q.lead_hi <= nxt.lead_hi;
      q.lead_lo <= nxt.lead_lo;
    end
  end

endmodule

// ===== rtl/lcbc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_classify
// Decides the brand from length, leading digits and the Luhn sum.
// ----------------------------------------------------------------------------
module lcbc_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lcbc_pkg::stage_t  d,
  output lcbc_pkg::result_t q
);

  logic             ok;
  lcbc_pkg::brand_t brand;

  always_comb begin
    ok    = (d.sum == '0);
    brand = lcbc_pkg::BRAND_INVALID;
    if (ok) begin
      case (d.count)
        lcbc_pkg::LenVisaShort: begin
          if (d.lead_hi == lcbc_pkg::LeadVisa) brand = lcbc_pkg::BRAND_VISA;
        end
        lcbc_pkg::LenAmex: begin
          if (d.lead_hi == lcbc_pkg::LeadAmexHi &&
              (d.lead_lo == lcbc_pkg::LeadAmexLoA || d.lead_lo == lcbc_pkg::LeadAmexLoB)) begin
            brand = lcbc_pkg::BRAND_AMEX;
          end
        end
        lcbc_pkg::LenLong: begin
          if (d.lead_hi == lcbc_pkg::LeadVisa) begin
            brand = lcbc_pkg::BRAND_VISA;
          end else if (d.lead_hi == lcbc_pkg::LeadMcHi &&
                       d.lead_lo inside {[lcbc_pkg::LeadMcLoMin:lcbc_pkg::LeadMcLoMax]}) begin
            brand = lcbc_pkg::BRAND_MASTERCARD;
          end
        end
        default: brand = lcbc_pkg::BRAND_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.brand       <= brand;
      q.checksum_ok <= ok;
      q.digit_count <= d.count;
    end
  end

endmodule

// ===== rtl/lcbc_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbc_out_buf
// Output register with a skid entry; its ready is a register output.
// ----------------------------------------------------------------------------
module lcbc_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  lcbc_pkg::result_t    up,
  output logic                 up_ready,
  lcbc_result_if.source        result
);

  logic              out_valid;
  lcbc_pkg::result_t out_data;
  logic              skid_valid;
  lcbc_pkg::result_t skid_data;
  logic              take;

  assign up_ready = !skid_valid;
  assign take     = up.valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : up;
    end else if (take) begin
      skid_data <= up;
    end
  end

  assign result.valid       = out_valid;
  assign result.brand       = out_data.brand;
  assign result.checksum_ok = out_data.checksum_ok;
  assign result.digit_count = out_data.digit_count;

  // Skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output empty");

  // A held result with a full skid entry keeps the skid entry
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid)
    else $error("skid entry dropped under stall");

endmodule

// ===== rtl/luhn_card_brand_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_brand_check
// Luhn mod-10 check and brand classification of a binary card number.
// ----------------------------------------------------------------------------
// Accepts one card number per cycle and returns one result per number, in
// order. Each number passes through 19 digit stages, which each peel off
// one decimal digit (most significant first) by comparing against the
// nine multiples of that digit's weight, one stage that registers the
// classification, and one output register with a skid entry that drives
// the result channel. Throughput is one transaction per cycle; the whole
// pipeline freezes only while the skid entry is occupied. brand is 0
// invalid, 1 amex (15 digits, 34/37), 2 mastercard (16 digits, 51..55),
// 3 visa (13 or 16 digits, leading 4); any brand requires checksum_ok.
// Zero gives digit_count 0, checksum_ok 1.
// ----------------------------------------------------------------------------
module luhn_card_brand_check (
  input  logic           clk,
  input  logic           rst,
  lcbc_card_if.sink      card,
  lcbc_result_if.source  check
);

  localparam int unsigned Depth = lcbc_pkg::NumDigits;

  // pipe[Depth] is the incoming transaction, pipe[0] holds units digit done
  lcbc_pkg::stage_t  pipe [0:Depth];
  lcbc_pkg::result_t classified;
  logic              en;

  // Advance every stage together; hold all while the skid entry is full
  assign card.ready = en;

  always_comb begin
    pipe[Depth]         = '0;
    pipe[Depth].valid   = card.valid;
    pipe[Depth].rest    = card.card_number;
  end

  for (genvar g = 0; g < Depth; g++) begin : g_digit
    lcbc_digit_stage #(
      .POS (g)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (pipe[g+1]),
      .q   (pipe[g])
    );
  end

  lcbc_classify u_classify (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (pipe[0]),
    .q   (classified)
  );

  lcbc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .up       (classified),
    .up_ready (en),
    .result   (check)
  );

  // A brand is only reported with a passing checksum
  a_brand_needs_ok: assert property (@(posedge clk) disable iff (rst)
    check.valid && check.brand != lcbc_pkg::BRAND_INVALID |-> check.checksum_ok)
    else $error("brand reported with failed checksum");

  // Amex results always carry fifteen digits
  a_amex_len: assert property (@(posedge clk) disable iff (rst)
    check.valid && check.brand == lcbc_pkg::BRAND_AMEX |-> check.digit_count == lcbc_pkg::LenAmex)
    else $error("amex result with wrong length");

  // After all digits are removed nothing remains of the number
  a_rest_cleared: assert property (@(posedge clk) disable iff (rst)
    pipe[0].valid |-> pipe[0].rest == '0)
    else $error("digit pipeline left a remainder");

endmodule
